>>> design/dafmt_pkg.sv
// package for the decimal ascii formatter
// holds the transaction structs, command bit positions and character codes
// no dependencies
`timescale 1ns / 1ps

package dafmt_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W = 2;
  localparam int CHAR_W = 8;

  // cmd bit positions
  localparam int CMD_SIGNED_BIT = 0;
  localparam int CMD_CRLF_BIT = 1;

  // a 32-bit magnitude never needs more than ten decimal digits
  localparam int DIGIT_SLOTS = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;
  } out_t;

endpackage

>>> design/decimal_ascii_formatter_unit.sv
// decimal ascii formatter top level
// bit-serial binary to bcd conversion followed by the result's characters, one per transfer
// depends on dafmt_pkg
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | dafmt_pkg::in_t  (cmd, value)
// out_    | output    | out_valid/out_stall | dafmt_pkg::out_t (ascii_char, last_char)
//
// one transaction at a time: acceptance, then a shift-and-correct step for each
// of the 32 value bits through the bcd shift register, a step for each dropped
// leading zero digit and one to leave that phase, then one character per cycle
// (1 to 13 at ten digits) while out_stall is low; the conversion loop shifts in
// one bit per cycle
// rst_n is synchronous and clears the sequencer and out_valid
// in_stall is high from acceptance until the last character is loaded

module decimal_ascii_formatter_unit #(
  parameter int MAX_DIGITS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dafmt_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dafmt_pkg::out_t out_data
);

  localparam int DIGS = (MAX_DIGITS < dafmt_pkg::DIGIT_SLOTS) ?
                        MAX_DIGITS : dafmt_pkg::DIGIT_SLOTS;
  localparam int BCD_W = 4 * DIGS;
  localparam int REM_W = $clog2(DIGS + 1);
  localparam int BIT_W = $clog2(dafmt_pkg::VALUE_W);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(dafmt_pkg::VALUE_W - 1);
  localparam logic [REM_W-1:0] REM_ONE = REM_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIG,
    S_CR,
    S_LF
  } state_t;

  state_t                         state_r, state_nxt;
  logic [dafmt_pkg::VALUE_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]               bcd_r, bcd_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           neg_r, neg_nxt;
  logic                           crlf_r, crlf_nxt;
  logic [BIT_W-1:0]               bit_cnt_r, bit_cnt_nxt;
  logic [REM_W-1:0]               rem_r, rem_nxt;
  logic                           out_valid_r, out_valid_nxt;
  dafmt_pkg::out_t                out_data_r, out_data_nxt;

  logic                           in_acc;
  logic                           out_free;
  logic                           in_neg;
  logic [BCD_W-1:0]               bcd_adj;
  logic [3:0]                     top_digit;

  assign in_acc = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_neg = in_data.cmd[dafmt_pkg::CMD_SIGNED_BIT] &&
                  in_data.value[dafmt_pkg::VALUE_W-1];
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 :
                          bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    ovf_nxt = ovf_r;
    neg_nxt = neg_r;
    crlf_nxt = crlf_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt = rem_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt = in_neg;
          crlf_nxt = in_data.cmd[dafmt_pkg::CMD_CRLF_BIT];
          mag_nxt = in_neg ? (~in_data.value + 32'd1) : in_data.value;
          bcd_nxt = '0;
          ovf_nxt = 1'b0;
          bit_cnt_nxt = '0;
          rem_nxt = REM_W'(DIGS);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[dafmt_pkg::VALUE_W-1]};
        mag_nxt = {mag_r[dafmt_pkg::VALUE_W-2:0], 1'b0};
        // a bit leaving the top digit means more digits than are kept
        ovf_nxt = ovf_r || bcd_adj[BCD_W-1];
        bit_cnt_nxt = bit_cnt_r + BIT_W'(1);
        if (bit_cnt_r == BIT_LAST) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!ovf_r && (top_digit == 4'd0) && (rem_r > REM_ONE)) begin
          bcd_nxt = bcd_r << 4;
          rem_nxt = rem_r - REM_ONE;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIG;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.ascii_char = dafmt_pkg::CHAR_MINUS;
          out_data_nxt.last_char = 1'b0;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.ascii_char = dafmt_pkg::CHAR_ZERO | {4'd0, top_digit};
          out_data_nxt.last_char = (rem_r == REM_ONE) && !crlf_r;
          bcd_nxt = bcd_r << 4;
          rem_nxt = rem_r - REM_ONE;
          if (rem_r == REM_ONE) begin
            state_nxt = crlf_r ? S_CR : S_IDLE;
          end
        end
      end
      S_CR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.ascii_char = dafmt_pkg::CHAR_CR;
          out_data_nxt.last_char = 1'b0;
          state_nxt = S_LF;
        end
      end
      S_LF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.ascii_char = dafmt_pkg::CHAR_LF;
          out_data_nxt.last_char = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
    crlf_r <= crlf_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rem_r <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a transaction");

  // conversion ends after the last bit
  a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) && (bit_cnt_r == BIT_LAST) |=> (state_r == S_SKIP))
    else $error("conversion did not end after the last bit");

  // digit count never runs out while digits are emitted
  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG) |-> (rem_r != '0))
    else $error("digit emission with no digit left");

  // nothing new is loaded while a stalled character waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && (state_r != S_CONV) && (state_r != S_SKIP) &&
    (state_r != S_IDLE) |=> $stable(state_r))
    else $error("sequencer advanced while output was stalled");

endmodule
